// ----- src/irrd_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// irrd_pkg
// Shared types and constants of the round-robin interrupt distributor.
// ============================================================================
package irrd_pkg;

    // Default sizes of the design.
    localparam int NUM_CPUS    = 4;
    localparam int NUM_SOURCES = 16;

    // Fixed field widths.
    localparam int CPU_BITS  = 4;   // affinity bits per source
    localparam int MASK_BITS = 16;  // width of the source masks
    localparam int SRC_W     = 4;
    localparam int CPU_W     = 2;
    localparam int PTR_W     = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 64;

    // Pointer value meaning no CPU has been chosen yet.
    localparam logic [PTR_W-1:0] PTR_NONE = 3'h7;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_AFFINITY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LOCAL    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SOURCE   = 2'd3;

    // Register reset values.
    localparam logic [CFG_W-1:0]     AFFINITY_RST = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [CPU_BITS-1:0]  ACTIVE_RST   = 4'h1;
    localparam logic [MASK_BITS-1:0] LOCAL_RST    = 16'h1187;
    localparam logic [MASK_BITS-1:0] SOURCE_RST   = 16'hD1FB;

    // What one lane proposes for its source.
    typedef struct packed {
        logic [CPU_W-1:0] cpu;
        logic             fwd;
        logic             upd;
    } t_lane_res;

    // The routing result chosen by the merge stage.
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [CPU_W-1:0] cpu;
        logic             fwd;
        logic             last;
    } t_pick;

endpackage

// ----- src/interrupt_round_robin_distributor_top.sv -----
`timescale 1ns / 1ps
// ============================================================================
// interrupt_round_robin_distributor_top
// Routes each pending, eligible interrupt source to a CPU, round-robin over
// the active CPUs in its affinity, one routing result per source.
// ============================================================================
//  Channel   Direction  Handshake              Payload
//  config    in         i_cfg_we               i_cfg_index, i_cfg_data
//  input     in         i_in_valid/o_in_ready  i_pending
//  output    out        o_out_valid/i_out_ready o_source_number, o_target_cpu,
//                                              o_forwarded, o_last
//
//  A request with pending eligible sources holds the input side from the accept
//  cycle until its last source is issued; the single merge stage picks one lane
//  per cycle while the output is not stalled, giving one result per source.
//  A request with no eligible source is absorbed with no result.
//  The next request is taken once all sources of the current one are issued;
//  the last result may still wait in the output register.
//  A stalled output holds its result and pauses the merge stage.
//  Reset is synchronous; it restores register defaults and clears pointers.
// ============================================================================
module interrupt_round_robin_distributor_top #(
    parameter int P_NUM_CPUS    = irrd_pkg::NUM_CPUS,
    parameter int P_NUM_SOURCES = irrd_pkg::NUM_SOURCES
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [irrd_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [irrd_pkg::CFG_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  logic [irrd_pkg::MASK_BITS-1:0] i_pending,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output logic [irrd_pkg::SRC_W-1:0]     o_source_number,
    output logic [irrd_pkg::CPU_W-1:0]     o_target_cpu,
    output logic                           o_forwarded,
    output logic                           o_last
);

    // Sources at or above the mask width are never eligible.
    localparam int L_LANES = (P_NUM_SOURCES < irrd_pkg::MASK_BITS) ?
                             P_NUM_SOURCES : irrd_pkg::MASK_BITS;

    logic [irrd_pkg::CFG_W-1:0]     r_affinity;
    logic [irrd_pkg::CPU_BITS-1:0]  r_active;
    logic [irrd_pkg::MASK_BITS-1:0] r_local;
    logic [irrd_pkg::MASK_BITS-1:0] r_source;

    logic [L_LANES-1:0]             r_remaining;
    logic [L_LANES-1:0]             n_remaining;
    logic                           r_out_valid;
    irrd_pkg::t_pick                r_pick;

    irrd_pkg::t_lane_res [L_LANES-1:0] w_lane_res;
    logic [L_LANES-1:0]             w_grant;
    logic [L_LANES-1:0]             w_next_rem;
    irrd_pkg::t_pick                w_pick;
    logic                           w_issue;
    logic                           w_accept;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_affinity <= irrd_pkg::AFFINITY_RST;
            r_active   <= irrd_pkg::ACTIVE_RST;
            r_local    <= irrd_pkg::LOCAL_RST;
            r_source   <= irrd_pkg::SOURCE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                irrd_pkg::REG_AFFINITY: r_affinity <= i_cfg_data;
                irrd_pkg::REG_ACTIVE:   r_active   <= i_cfg_data[irrd_pkg::CPU_BITS-1:0];
                irrd_pkg::REG_LOCAL:    r_local    <= i_cfg_data[irrd_pkg::MASK_BITS-1:0];
                irrd_pkg::REG_SOURCE:   r_source   <= i_cfg_data[irrd_pkg::MASK_BITS-1:0];
                default: ;
            endcase
        end
    end

    // One lane per source.
    for (genvar g = 0; g < L_LANES; g++) begin : g_lane
        irrd_lane #(
            .P_NUM_CPUS (P_NUM_CPUS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_aff    (r_affinity[g*irrd_pkg::CPU_BITS +: irrd_pkg::CPU_BITS]),
            .i_active (r_active),
            .i_local  (r_local[g]),
            .i_commit (w_issue && w_grant[g]),
            .o_res    (w_lane_res[g])
        );
    end

    irrd_merge #(
        .P_LANES (L_LANES)
    ) u_merge (
        .i_remaining      (r_remaining),
        .i_lane_res       (w_lane_res),
        .o_grant          (w_grant),
        .o_next_remaining (w_next_rem),
        .o_pick           (w_pick)
    );

    // Handshakes: a new request only when every source is issued.
    assign o_in_ready = (r_remaining == '0);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_issue    = (r_remaining != '0) && (!r_out_valid || i_out_ready);

    // Next set of sources still to route.
    always_comb begin
        n_remaining = r_remaining;
        if (w_accept) begin
            n_remaining = i_pending[L_LANES-1:0] & r_source[L_LANES-1:0];
        end else if (w_issue) begin
            n_remaining = w_next_rem;
        end
    end

    // Source tracking and output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_remaining <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_remaining <= n_remaining;
            if (w_issue) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (w_issue) begin
            r_pick <= w_pick;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_source_number = r_pick.src;
    assign o_target_cpu    = r_pick.cpu;
    assign o_forwarded     = r_pick.fwd;
    assign o_last          = r_pick.last;

    // Each issue retires exactly one source.
    a_one_per_issue : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_issue |=> ($countones(r_remaining) == $countones($past(r_remaining)) - 1))
        else $error("issue did not retire exactly one source");

    // The last result of a request leaves nothing pending.
    a_last_empties : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_issue && w_pick.last) |=> (r_remaining == '0))
        else $error("sources remain after last result");

    // Forwarding happens exactly for a nonzero target.
    a_fwd_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_forwarded == (o_target_cpu != '0)))
        else $error("forwarded flag disagrees with target CPU");

    // At most one lane is granted.
    a_grant_onehot : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(w_grant))
        else $error("more than one lane granted");

endmodule

// ----- src/irrd_lane.sv -----
`timescale 1ns / 1ps
// ============================================================================
// irrd_lane
// One source lane: holds the source's last-CPU pointer and works out the
// round-robin target for that source.
// ============================================================================
module irrd_lane #(
    parameter int P_NUM_CPUS = irrd_pkg::NUM_CPUS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [irrd_pkg::CPU_BITS-1:0] i_aff,
    input  logic [irrd_pkg::CPU_BITS-1:0] i_active,
    input  logic                          i_local,
    input  logic                          i_commit,
    output irrd_pkg::t_lane_res           o_res
);

    logic [irrd_pkg::PTR_W-1:0]    r_ptr;
    logic [irrd_pkg::CPU_BITS-1:0] w_limit;
    logic [irrd_pkg::CPU_BITS-1:0] w_set;
    logic [irrd_pkg::CPU_BITS-1:0] w_upper;
    logic [irrd_pkg::CPU_W-1:0]    w_low_set;
    logic [irrd_pkg::CPU_W-1:0]    w_low_upper;

    // CPUs beyond the configured count are never candidates.
    always_comb begin
        for (int c = 0; c < irrd_pkg::CPU_BITS; c++) begin
            w_limit[c] = (c < P_NUM_CPUS);
        end
    end

    assign w_set = i_aff & i_active & w_limit;

    // Candidates strictly above the pointer; none when no CPU was chosen yet.
    always_comb begin
        for (int c = 0; c < irrd_pkg::CPU_BITS; c++) begin
            w_upper[c] = w_set[c] && (r_ptr != irrd_pkg::PTR_NONE)
                         && (irrd_pkg::PTR_W'(c) > r_ptr);
        end
    end

    // Lowest set CPU of each candidate group.
    always_comb begin
        w_low_set   = '0;
        w_low_upper = '0;
        for (int c = irrd_pkg::CPU_BITS - 1; c >= 0; c--) begin
            if (w_set[c]) begin
                w_low_set = irrd_pkg::CPU_W'(c);
            end
            if (w_upper[c]) begin
                w_low_upper = irrd_pkg::CPU_W'(c);
            end
        end
    end

    // Local sources and sources with no active CPU in their affinity stay on CPU 0 and keep the pointer.
    always_comb begin
        o_res = '0;
        if (!i_local && (w_set != '0)) begin
            o_res.cpu = (w_upper != '0) ? w_low_upper : w_low_set;
            o_res.fwd = (o_res.cpu != '0);
            o_res.upd = 1'b1;
        end
    end

    // Pointer advances when this lane's request is issued.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= irrd_pkg::PTR_NONE;
        end else if (i_commit && o_res.upd) begin
            r_ptr <= irrd_pkg::PTR_W'(o_res.cpu);
        end
    end

endmodule

// ----- src/irrd_merge.sv -----
`timescale 1ns / 1ps
// ============================================================================
// irrd_merge
// Merge stage: picks the lowest remaining source and gathers its lane result.
// ============================================================================
module irrd_merge #(
    parameter int P_LANES = irrd_pkg::NUM_SOURCES
) (
    input  logic [P_LANES-1:0]        i_remaining,
    input  irrd_pkg::t_lane_res [P_LANES-1:0] i_lane_res,
    output logic [P_LANES-1:0]        o_grant,
    output logic [P_LANES-1:0]        o_next_remaining,
    output irrd_pkg::t_pick           o_pick
);

    // Isolate the lowest set bit.
    assign o_grant          = i_remaining & (~i_remaining + P_LANES'(1));
    assign o_next_remaining = i_remaining & ~o_grant;

    // One-hot gather of the granted lane.
    always_comb begin
        o_pick = '0;
        for (int i = 0; i < P_LANES; i++) begin
            if (o_grant[i]) begin
                o_pick.src = o_pick.src | irrd_pkg::SRC_W'(i);
                o_pick.cpu = o_pick.cpu | i_lane_res[i].cpu;
                o_pick.fwd = o_pick.fwd | i_lane_res[i].fwd;
            end
        end
        o_pick.last = (o_next_remaining == '0);
    end

endmodule
